@@ design/iirdf1_pkg.sv @@
// ----------------------------------------------------------------------------
// iirdf1_pkg: shared types and constants of the direct-form-I biquad filter
// Sample and coefficient formats, tap counts, register indexes and the
// control and payload structs passed between the filter modules.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  // Data formats: signed 16-bit samples, Q2.14 coefficients
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int TERM_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 4;

  // Tap counts (a0 is counted but never used; it is taken as 1)
  localparam int FEEDFORWARD_TAPS = 3;
  localparam int FEEDBACK_TAPS    = 3;

  // Delay cells: one per stored history entry
  localparam int NUM_CELLS = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 16'sd16384;

  // Rounding and saturation limits in accumulator width
  localparam logic signed [ACC_W-1:0] ACC_RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] ACC_OUT_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] ACC_OUT_MIN  = ACC_W'(-32768);
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX   = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN   = 16'sh8000;

  // Per-item control shared by all delay cells
  typedef struct packed {
    logic shift;   // item accepted: history moves one cell along
    logic clear;   // start of block: history reads as zero
  } cell_ctl_t;

  // One result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } result_t;

endpackage

@@ design/iirdf1_if.sv @@
// ----------------------------------------------------------------------------
// iirdf1_if: streaming channels of the biquad filter
// Input channel carries a sample and a start-of-block flag; the result
// channel carries the filtered sample and its saturation flag.
// ----------------------------------------------------------------------------
interface iirdf1_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink (input valid, input sample_in, input block_start, output ready);
endinterface

interface iirdf1_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

@@ design/iirdf1_tap_cell.sv @@
// ----------------------------------------------------------------------------
// iirdf1_tap_cell: one delay cell of the direct-form-I biquad
// Holds one delayed input and one delayed output, forms its tap term
// b*x - a*y and hands its history to the next cell on every item.
// ----------------------------------------------------------------------------
module iirdf1_tap_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  iirdf1_pkg::cell_ctl_t                  ctl,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_b,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_a,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_in,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_in,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_fwd,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_fwd,
  output logic signed [iirdf1_pkg::TERM_W-1:0]   term
);

  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_r, y_nxt;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_b;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_a;

  // History as seen by the current item: zero at start of block
  assign x_fwd = ctl.clear ? '0 : x_r;
  assign y_fwd = ctl.clear ? '0 : y_r;

  // Tap term
  assign prod_b = iirdf1_pkg::PROD_W'(coef_b) * iirdf1_pkg::PROD_W'(x_fwd);
  assign prod_a = iirdf1_pkg::PROD_W'(coef_a) * iirdf1_pkg::PROD_W'(y_fwd);
  assign term   = iirdf1_pkg::TERM_W'(prod_b) - iirdf1_pkg::TERM_W'(prod_a);

  // Shift in from the neighbor when an item is taken
  assign x_nxt = ctl.shift ? x_in : x_r;
  assign y_nxt = ctl.shift ? y_in : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

@@ design/iirdf1_out_skid.sv @@
// ----------------------------------------------------------------------------
// iirdf1_out_skid: result register with skid stage
// Keeps the input side running while the receiver stalls; the ready it
// returns depends on registers only.
// ----------------------------------------------------------------------------
module iirdf1_out_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iirdf1_pkg::result_t push_data,
  output logic                can_push,
  iirdf1_out_if.source        out_chan
);

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  iirdf1_pkg::result_t out_data_r, out_data_nxt;
  iirdf1_pkg::result_t skid_data_r, skid_data_nxt;
  logic                out_fire;

  assign out_fire = out_valid_r & out_chan.ready;
  assign can_push = ~skid_valid_r;

  // Output register loads from skid first, else from the new item
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r.sample_out;
  assign out_chan.clipped    = out_data_r.clipped;

  // A parked item always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  // An item pushed into a stalled output lands in the skid stage
  a_push_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_chan.ready) |=> skid_valid_r)
    else $error("item pushed during stall was not parked");

endmodule

@@ design/iir_filter_direct_form_one.sv @@
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one: streaming direct-form-I biquad filter
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 in fixed point (Q2.14
// coefficients, 16-bit samples), rounded half up and saturated.
//
// Usage:
//   in_chan  : sample_in and block_start, valid/ready; one item per sample.
//              block_start clears both histories before its sample is used.
//   out_chan : sample_out and clipped, one result item per input item.
//   cfg_*    : write enable, register index (b0, b1, b2, a1, a2) and
//              16-bit data; write only while no item is in flight.
//   Result: each result is registered when its item is accepted.
//   Throughput: one item per cycle while the skid entry is empty; the whole
//   tap sum, round and saturate run in the cycle the item is accepted,
//   since the next item needs this output in the feedback delay cells.
//   Stall: a result register plus one skid entry hold results; in_ready
//   drops only once both are full, and comes back when the receiver takes.
//   Reset: histories clear to zero, b0 = 1.0, all other coefficients zero,
//   no result pending.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_one (
  input  logic                                       clk,
  input  logic                                       rst_n,
  iirdf1_in_if.sink                                  in_chan,
  iirdf1_out_if.source                               out_chan,
  input  logic                                       cfg_we,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int NC = iirdf1_pkg::NUM_CELLS;

  // Coefficient registers
  logic signed [iirdf1_pkg::COEF_W-1:0] coef_b0_r;
  logic signed [iirdf1_pkg::COEF_W-1:0] coef_b_r [1:NC];
  logic signed [iirdf1_pkg::COEF_W-1:0] coef_a_r [1:NC];

  // Cell chain
  iirdf1_pkg::cell_ctl_t                  cell_ctl;
  logic signed [iirdf1_pkg::COEF_W-1:0]   cell_cb [1:NC];
  logic signed [iirdf1_pkg::COEF_W-1:0]   cell_ca [1:NC];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] cell_xin [1:NC];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] cell_yin [1:NC];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_fwd [1:NC];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_fwd [1:NC];
  logic signed [iirdf1_pkg::TERM_W-1:0]   term [1:NC];

  logic                                   in_acc;
  logic                                   can_push;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_b0;
  logic signed [iirdf1_pkg::ACC_W-1:0]    acc_sum;
  logic signed [iirdf1_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_sat;
  iirdf1_pkg::result_t                    res;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r   <= iirdf1_pkg::COEF_B0_RST;
      coef_b_r[1] <= '0;
      coef_b_r[2] <= '0;
      coef_a_r[1] <= '0;
      coef_a_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (iirdf1_pkg::cfg_reg_t'(cfg_index))
        iirdf1_pkg::CFG_B0: coef_b0_r   <= cfg_data;
        iirdf1_pkg::CFG_B1: coef_b_r[1] <= cfg_data;
        iirdf1_pkg::CFG_B2: coef_b_r[2] <= cfg_data;
        iirdf1_pkg::CFG_A1: coef_a_r[1] <= cfg_data;
        iirdf1_pkg::CFG_A2: coef_a_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_chan.ready  = can_push;
  assign in_acc         = in_chan.valid & can_push;
  assign cell_ctl.shift = in_acc;
  assign cell_ctl.clear = in_chan.block_start;

  // Row of delay cells; cell k holds x[n-k] and y[n-k]
  for (genvar k = 1; k <= NC; k++) begin : g_cell
    assign cell_cb[k] = (k < iirdf1_pkg::FEEDFORWARD_TAPS) ? coef_b_r[k] : '0;
    assign cell_ca[k] = (k < iirdf1_pkg::FEEDBACK_TAPS) ? coef_a_r[k] : '0;
    if (k == 1) begin : g_head
      assign cell_xin[k] = in_chan.sample_in;
      assign cell_yin[k] = y_sat;
    end else begin : g_body
      assign cell_xin[k] = x_fwd[k-1];
      assign cell_yin[k] = y_fwd[k-1];
    end
    iirdf1_tap_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl),
      .coef_b (cell_cb[k]),
      .coef_a (cell_ca[k]),
      .x_in   (cell_xin[k]),
      .y_in   (cell_yin[k]),
      .x_fwd  (x_fwd[k]),
      .y_fwd  (y_fwd[k]),
      .term   (term[k])
    );
  end

  // Current-sample tap
  assign prod_b0 = iirdf1_pkg::PROD_W'(coef_b0_r) * iirdf1_pkg::PROD_W'(in_chan.sample_in);

  // Tap sum plus half LSB for rounding
  always_comb begin
    acc_sum = iirdf1_pkg::ACC_W'(prod_b0) + iirdf1_pkg::ACC_RND_HALF;
    for (int i = 1; i <= NC; i++) begin
      acc_sum = acc_sum + iirdf1_pkg::ACC_W'(term[i]);
    end
  end

  // Floor shift, then saturate
  assign acc_rnd = acc_sum >>> iirdf1_pkg::FRAC_BITS;

  always_comb begin
    res.clipped = 1'b0;
    if (acc_rnd > iirdf1_pkg::ACC_OUT_MAX) begin
      y_sat       = iirdf1_pkg::OUT_MAX;
      res.clipped = 1'b1;
    end else if (acc_rnd < iirdf1_pkg::ACC_OUT_MIN) begin
      y_sat       = iirdf1_pkg::OUT_MIN;
      res.clipped = 1'b1;
    end else begin
      y_sat = acc_rnd[iirdf1_pkg::SAMPLE_W-1:0];
    end
    res.sample_out = y_sat;
  end

  // Result register and skid
  iirdf1_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .can_push  (can_push),
    .out_chan  (out_chan)
  );

  // A clipped result always sits at one of the rails
  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.clipped) |->
      (out_chan.sample_out == iirdf1_pkg::OUT_MAX ||
       out_chan.sample_out == iirdf1_pkg::OUT_MIN))
    else $error("clipped result is not at a saturation rail");

  // The first delay cell picks up the accepted sample
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (in_chan.block_start || x_fwd[1] == $past(in_chan.sample_in)))
    else $error("input history did not take the accepted sample");

endmodule
